// File: rtl/sod_pkg.sv
// Shared types and constants for the sonar obstacle debounce block.
package sod_pkg;

	localparam int unsigned DistW  = 16;
	localparam int unsigned CountW = 7;
	localparam int unsigned AngleW = 9;
	localparam int unsigned HoldW  = 16;
	localparam int unsigned TimeW  = 32;

	localparam logic [CountW-1:0] SatCount = 7'd127;

	localparam logic [DistW-1:0]  TriggerReset  = 16'd100;
	localparam logic [CountW-1:0] DebounceReset = 7'd2;
	localparam logic [AngleW-1:0] AngleReset    = 9'd45;
	localparam logic [HoldW-1:0]  HoldReset     = 16'd1000;

	typedef enum logic [1:0] {
		REG_TRIGGER  = 2'd0,
		REG_DEBOUNCE = 2'd1,
		REG_ANGLE    = 2'd2,
		REG_HOLD     = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ANN_NONE  = 2'd0,
		ANN_LEFT  = 2'd1,
		ANN_RIGHT = 2'd2,
		ANN_FRONT = 2'd3
	} announce_t;

	typedef struct packed {
		logic        [DistW-1:0]  trigger_cm;
		logic        [CountW-1:0] debounce;
		logic signed [AngleW-1:0] angle;
		logic        [HoldW-1:0]  hold_ms;
	} cfg_t;

	typedef struct packed {
		logic        [DistW-1:0]  left_cm;
		logic        [DistW-1:0]  right_cm;
		logic        [CountW-1:0] count;
		logic        [TimeW-1:0]  last_hit_ms;
		logic signed [AngleW-1:0] steer;
	} track_t;

endpackage

// File: rtl/sod_step.sv
// Next-state logic for one sensor update of the obstacle tracker.
module sod_step (
	input  sod_pkg::cfg_t                  cfg,
	input  sod_pkg::track_t                cur,
	input  logic                           connected,
	input  logic                           dual,
	input  logic [sod_pkg::DistW-1:0]      left_cm,
	input  logic [sod_pkg::DistW-1:0]      right_cm,
	input  logic [sod_pkg::TimeW-1:0]      now_ms,
	output sod_pkg::track_t                nxt,
	output sod_pkg::announce_t             announce,
	output logic                           passed
);
	import sod_pkg::*;

	logic                     left_near;
	logic                     right_near;
	logic                     hit;
	logic signed [AngleW-1:0] hit_steer;
	announce_t                side;
	logic [CountW-1:0]        count_hit;
	logic [TimeW-1:0]         last_hit;
	logic [TimeW:0]           deadline;
	logic                     expired;

	always_comb begin
		left_near  = (left_cm <= cfg.trigger_cm);
		right_near = (right_cm <= cfg.trigger_cm);
		hit        = 1'b0;
		hit_steer  = cfg.angle;
		side       = ANN_NONE;
		if (dual) begin
			if (left_near && (left_cm <= right_cm)) begin
				hit  = 1'b1;
				side = ANN_LEFT;
			end else if (right_near) begin
				hit       = 1'b1;
				hit_steer = AngleW'(-cfg.angle);
				side      = ANN_RIGHT;
			end
		end else if (left_near) begin
			hit  = 1'b1;
			side = ANN_FRONT;
		end

		count_hit = cur.count;
		last_hit  = cur.last_hit_ms;
		if (hit) begin
			if (cur.count < SatCount) begin
				count_hit = cur.count + CountW'(1);
			end
			last_hit = now_ms;
		end

		deadline = {1'b0, last_hit} + {{(TimeW + 1 - HoldW){1'b0}}, cfg.hold_ms};
		expired  = ({1'b0, now_ms} > deadline) && (count_hit >= cfg.debounce);

		nxt      = cur;
		announce = ANN_NONE;
		passed   = 1'b0;
		if (connected) begin
			nxt.left_cm     = left_cm;
			nxt.right_cm    = dual ? right_cm : '0;
			nxt.count       = count_hit;
			nxt.last_hit_ms = last_hit;
			if (hit) begin
				nxt.steer = hit_steer;
				if (count_hit == cfg.debounce) begin
					announce = side;
				end
			end
			if (expired) begin
				nxt.count = '0;
				nxt.steer = '0;
				passed    = 1'b1;
			end
		end
	end

endmodule

// File: rtl/sonar_obstacle_debounce.sv
// Top level of the sonar obstacle debounce block.
//
// Each input word is one rangefinder update. The tracker state is updated at
// the edge that accepts the word, and one result word per input word appears
// in the output register on the next cycle. Throughput is one word per cycle
// while the receiver takes each result: the only loop is the tracker state,
// which one pass of compares, an increment and a 33-bit add and compare
// updates. The input side is ready whenever the output register is empty or
// is being taken in the same cycle; a stalled receiver holds its word in
// place and stalls the sender until it is taken.
// Configuration writes land at the edge where cfg_we is high and should be
// made while no word is in flight.
// Reset clears the tracker state, the output valid flag and loads the
// register defaults: trigger 100 cm, debounce 2 hits, turn 45 degrees and
// hold time 1000 ms.
module sonar_obstacle_debounce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// left_distance_cm, right_distance_cm, now_ms
	input  logic [63:0] s_tdata,
	// sensor_connected, dual_sensors
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// stored_left_cm, stored_right_cm, steer_angle_deg, hit_count, announce,
	// obstacle_passed, zero fill
	output logic [55:0] m_tdata
);
	import sod_pkg::*;

	cfg_t      cfg_q;
	track_t    track_q;
	track_t    track_nxt;
	announce_t announce;
	logic      passed;
	logic      accept;
	logic      m_tvalid_q;
	logic [55:0] m_tdata_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trigger_cm <= TriggerReset;
			cfg_q.debounce   <= DebounceReset;
			cfg_q.angle      <= AngleReset;
			cfg_q.hold_ms    <= HoldReset;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_TRIGGER:  cfg_q.trigger_cm <= cfg_wdata[DistW-1:0];
				REG_DEBOUNCE: cfg_q.debounce   <= cfg_wdata[CountW-1:0];
				REG_ANGLE:    cfg_q.angle      <= cfg_wdata[AngleW-1:0];
				REG_HOLD:     cfg_q.hold_ms    <= cfg_wdata[HoldW-1:0];
				default:      cfg_q            <= cfg_q;
			endcase
		end
	end

	sod_step u_step (
		.cfg       (cfg_q),
		.cur       (track_q),
		.connected (s_tuser[0]),
		.dual      (s_tuser[1]),
		.left_cm   (s_tdata[15:0]),
		.right_cm  (s_tdata[31:16]),
		.now_ms    (s_tdata[63:32]),
		.nxt       (track_nxt),
		.announce  (announce),
		.passed    (passed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				track_q    <= track_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {5'b0, passed, announce, track_nxt.count, track_nxt.steer,
				track_nxt.right_cm, track_nxt.left_cm};
		end
	end

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[50] && (m_tdata[49:48] != ANN_NONE)))
		else $error("announce and passed flagged in the same word");

	a_passed_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[50]) |-> (m_tdata[47:32] == '0))
		else $error("passed word carries a nonzero count or steer");

	a_accept_valid: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (m_tvalid && (track_q.count == m_tdata[47:41])))
		else $error("accepted word not presented with the updated count");

endmodule
